[rtl/cda_pkg.sv]
// Shared types, constants and calendar functions of the calendar date advance block.
package cda_pkg;

	// Width of the internal year counter; the largest reachable year is all ones.
	localparam int YEAR_BITS = 14;
	localparam logic [YEAR_BITS-1:0] YEAR_MAX = {YEAR_BITS{1'b1}};

	// Width of the configured day count.
	localparam int DAYS_BITS = 16;
	localparam logic [DAYS_BITS-1:0] DAYS_RESET = 16'd1000;

	// The year is reduced modulo 400 by compare and subtract of 400 shifted left.
	// Since 400 >= 2^8, the quotient has at most YEAR_BITS-8 bits.
	localparam int RED_STEPS = YEAR_BITS - 7;
	localparam int RED_IDX_BITS = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
	localparam logic [RED_IDX_BITS-1:0] RED_IDX_FIRST = RED_IDX_BITS'(RED_STEPS - 1);
	localparam int REM_BITS = YEAR_BITS + 1;
	localparam logic [REM_BITS-1:0] REM_BASE = REM_BITS'(400);

	// Year position within the 400-year Gregorian cycle.
	localparam logic [8:0] CYC_LAST = 9'd399;
	localparam logic [8:0] CYC_C1 = 9'd100;
	localparam logic [8:0] CYC_C2 = 9'd200;
	localparam logic [8:0] CYC_C3 = 9'd300;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_DEC = 4'd12;
	localparam logic [4:0] DAY_FIRST = 5'd1;

	typedef struct packed {
		logic [4:0]  start_day;
		logic [3:0]  start_month;
		logic [13:0] start_year;
	} in_req_t;

	typedef struct packed {
		logic [4:0]  end_day;
		logic [3:0]  end_month;
		logic [13:0] end_year;
		logic        date_valid;
		logic        year_overflow;
	} out_res_t;

	typedef struct packed {
		logic load;
		logic reduce;
		logic check;
		logic step;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic red_last;
		logic stop;
	} dp_sts_t;

	// Leap year from the year modulo 400; 400 is a multiple of 4, so the low
	// two bits of the remainder match those of the year.
	function automatic logic is_leap(input logic [8:0] cyc);
		logic century;
		century = (cyc == CYC_C1) || (cyc == CYC_C2) || (cyc == CYC_C3);
		return (cyc[1:0] == 2'b00) && !century;
	endfunction

	// Days in a month; months outside 1 to 12 have none.
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] len;
		case (month)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			MONTH_FEB: len = leap ? 5'd29 : 5'd28;
			default: len = 5'd0;
		endcase
		return len;
	endfunction

endpackage

[rtl/cda_datapath.sv]
// Datapath of the calendar date advance block: date registers, year reduction and day stepping.
module cda_datapath import cda_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [DAYS_BITS-1:0] cfg_wr_data,
	input  in_req_t              in_data,
	input  dp_cmd_t              cmd,
	output dp_sts_t              sts,
	output out_res_t             out_data
);

	logic [DAYS_BITS-1:0]    days_to_add_q;
	logic [DAYS_BITS-1:0]    cnt_q;
	logic [RED_IDX_BITS-1:0] k_q;
	logic                    ok_q;
	logic [4:0]              day_q;
	logic [3:0]              month_q;
	logic [YEAR_BITS-1:0]    year_q;
	logic [REM_BITS-1:0]     rem_q;
	logic [8:0]              cyc_q;
	out_res_t                out_q;

	logic [REM_BITS-1:0] red_sub;
	logic [4:0]          dim_cur;
	logic [4:0]          dim_chk;
	logic                date_ok;
	logic                at_limit;
	logic                cnt_zero;

	assign red_sub  = REM_BASE << k_q;
	assign dim_cur  = month_days(month_q, is_leap(cyc_q));
	assign dim_chk  = month_days(month_q, is_leap(rem_q[8:0]));
	assign date_ok  = (month_q >= MONTH_JAN) && (month_q <= MONTH_DEC) &&
	                  (day_q >= DAY_FIRST) && (day_q <= dim_chk);
	assign at_limit = (month_q == MONTH_DEC) && (day_q == dim_cur) && (year_q == YEAR_MAX);
	assign cnt_zero = (cnt_q == '0);

	assign sts.red_last = (k_q == '0);
	assign sts.stop     = cnt_zero || at_limit;
	assign out_data     = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			days_to_add_q <= DAYS_RESET;
			cnt_q <= '0;
			k_q <= '0;
			ok_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				days_to_add_q <= cfg_wr_data;
			end
			if (cmd.load) begin
				cnt_q <= days_to_add_q;
				k_q <= RED_IDX_FIRST;
			end else if (cmd.reduce) begin
				k_q <= k_q - 1'b1;
			end else if (cmd.check) begin
				ok_q <= date_ok;
				if (!date_ok) begin
					cnt_q <= '0;
				end
			end else if (cmd.step) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			day_q <= in_data.start_day;
			month_q <= in_data.start_month;
			year_q <= YEAR_BITS'(in_data.start_year);
			rem_q <= REM_BITS'(YEAR_BITS'(in_data.start_year));
		end else if (cmd.reduce) begin
			if (rem_q >= red_sub) begin
				rem_q <= rem_q - red_sub;
			end
		end else if (cmd.check) begin
			cyc_q <= rem_q[8:0];
		end else if (cmd.step) begin
			if (day_q < dim_cur) begin
				day_q <= day_q + 1'b1;
			end else if (month_q < MONTH_DEC) begin
				day_q <= DAY_FIRST;
				month_q <= month_q + 1'b1;
			end else begin
				// Year rollover; the controller never steps past the last year.
				day_q <= DAY_FIRST;
				month_q <= MONTH_JAN;
				year_q <= year_q + 1'b1;
				cyc_q <= (cyc_q == CYC_LAST) ? 9'd0 : cyc_q + 1'b1;
			end
		end
		if (cmd.publish) begin
			if (ok_q) begin
				out_q.end_day <= day_q;
				out_q.end_month <= month_q;
				out_q.end_year <= 14'(year_q);
				out_q.date_valid <= 1'b1;
				out_q.year_overflow <= !cnt_zero && at_limit;
			end else begin
				out_q <= '0;
			end
		end
	end

endmodule

[rtl/cda_ctrl.sv]
// Controller of the calendar date advance block: sequences reduction, check and stepping.
module cda_ctrl import cda_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_CHECK,
		ST_STEP
	} ctl_state_t;

	ctl_state_t state_q;
	logic       out_valid_q;
	logic       slot_free;

	assign slot_free   = !out_valid_q || out_ready;
	assign in_ready    = (state_q == ST_IDLE);
	assign out_valid   = out_valid_q;

	always_comb begin
		cmd = '0;
		cmd.load    = (state_q == ST_IDLE) && in_valid;
		cmd.reduce  = (state_q == ST_REDUCE);
		cmd.check   = (state_q == ST_CHECK);
		cmd.step    = (state_q == ST_STEP) && !sts.stop;
		cmd.publish = (state_q == ST_STEP) && sts.stop && slot_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_REDUCE;
					end
				end
				ST_REDUCE: begin
					if (sts.red_last) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (cmd.publish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/calendar_date_advance.sv]
// Top level of the calendar date advance block: Gregorian date plus a configured day count.
//
// Each request carries a date (day, month, year). The block reduces the year modulo 400 with
// one compare and subtract per cycle, checks the date, and then advances it one day per
// cycle, so the datapath's single-day stepping loop sets the rate. An invalid date (month not
// 1 to 12, or day outside its month) gives an all-zero result with date_valid clear. February
// has 29 days in years divisible by 400, or by 4 but not by 100; year 0 counts as a leap
// year. Stepping past December 31 of the largest year holds the date there, drops the
// remaining days and sets year_overflow. The finished result sits in an output register, so
// the next request is taken while that result still waits for out_ready. days_to_add is
// written through cfg_wr_en and cfg_wr_data and should only change while the
// block is idle.
module calendar_date_advance import cda_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [DAYS_BITS-1:0] cfg_wr_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_req_t              in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_res_t             out_data
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// The controller owns the handshakes and the sequence of phases.
	cda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the configuration register, the date and the result register.
	cda_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_data     (in_data),
		.cmd         (cmd),
		.sts         (sts),
		.out_data    (out_data)
	);

`ifndef NO_ASSERTIONS
	// Once a request is taken, the block is busy on the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("block ready right after accepting a request");

	// A rejected date gives an all-zero result.
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.date_valid |-> out_data.end_day == 5'd0 &&
		out_data.end_month == 4'd0 && out_data.end_year == 14'd0 && !out_data.year_overflow)
		else $error("invalid date result not zero");

	// A valid result has a month from 1 to 12 and a day of at least 1.
	a_valid_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.date_valid |-> out_data.end_month >= MONTH_JAN &&
		out_data.end_month <= MONTH_DEC && out_data.end_day >= DAY_FIRST)
		else $error("valid result out of calendar range");

	// Saturation holds the date at December 31.
	a_overflow_dec31: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.year_overflow |-> out_data.date_valid &&
		out_data.end_month == MONTH_DEC && out_data.end_day == 5'd31)
		else $error("overflow result not at December 31");
`endif

endmodule
